### rtl/core/ppf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppf_pkg
// shared constants and codes for the perceptron prefetch filter
// ----------------------------------------------------------------------------
package ppf_pkg;
	localparam int WGT_WIDTH_D      = 5;
	localparam int FEAT_WIDTH_D     = 12;
	localparam int FEATURE_COUNT    = 4;
	localparam int REJECT_ENTRIES_D = 1024;
	localparam int ACCEPT_ENTRIES_D = 1024;
	localparam int ADDRESS_BITS_D   = 48;
	localparam int SUM_BITS         = 7;
	localparam int CONF_BITS        = 13;

	localparam logic [1:0] ACT_DEMAND   = 2'd0;
	localparam logic [1:0] ACT_CAND     = 2'd1;
	localparam logic [1:0] ACT_EVICT    = 2'd2;
	localparam logic [1:0] ACT_UNUSED   = 2'd3;

	localparam logic [1:0] DEC_NONE     = 2'd0;
	localparam logic [1:0] DEC_ACCEPT   = 2'd1;
	localparam logic [1:0] DEC_REJECT   = 2'd2;

	localparam logic [2:0] REG_PERMIT   = 3'd0;
	localparam logic [2:0] REG_STEP     = 3'd1;
	localparam logic [2:0] REG_RAISE    = 3'd2;
	localparam logic [2:0] REG_LOWER    = 3'd3;
	localparam logic [2:0] REG_PSHIFT   = 3'd4;
endpackage

### rtl/core/ppf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppf_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module ppf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

### rtl/core/perceptron_prefetch_filter.sv
`timescale 1ns / 1ps
// flow: a candidate reads and sums the weights of its four features, then decides; a demand
// looks up the reject table, then the accept table, an eviction only the accept table; each
// table hit reads and sums the weights and may train them; action 3 goes straight to output
// throughput: one item at a time, a new item is taken only once the last result has left;
// weight traffic goes through one ram port and one shared adder
// reset: control clears at once, then a sweep of the largest ram depth (4096 by default)
// ----------------------------------------------------------------------------
// perceptron_prefetch_filter
// perceptron filter deciding on prefetch candidates, trained by demand and eviction
// ----------------------------------------------------------------------------
module perceptron_prefetch_filter #(
	parameter int WGT_WIDTH      = ppf_pkg::WGT_WIDTH_D,
	parameter int FEAT_WIDTH     = ppf_pkg::FEAT_WIDTH_D,
	parameter int REJECT_ENTRIES = ppf_pkg::REJECT_ENTRIES_D,
	parameter int ACCEPT_ENTRIES = ppf_pkg::ACCEPT_ENTRIES_D,
	parameter int ADDRESS_BITS   = ppf_pkg::ADDRESS_BITS_D
) (
	input  logic        clk,
	input  logic        arst_n,
	// input item
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: target_address, trigger_address, confidence_code (lowest bit up)
	input  logic [((2*ADDRESS_BITS+ppf_pkg::CONF_BITS+7)/8)*8-1:0] s_axis_tdata,
	// tuser: action
	input  logic [1:0]  s_axis_tuser,
	// result item
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: perceptron_sum, raise_count, lowered, padding
	output logic [15:0] m_axis_tdata,
	// tuser: decision
	output logic [1:0]  m_axis_tuser,
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	import ppf_pkg::*;

	// table entry counts are powers of two, the index is the low target bits
	localparam int FB = FEAT_WIDTH;
	localparam int WB = WGT_WIDTH;
	localparam int AB = ADDRESS_BITS;
	localparam int RIB = $clog2(REJECT_ENTRIES);
	localparam int AIB = $clog2(ACCEPT_ENTRIES);
	localparam int ROW = FEATURE_COUNT * WB;
	localparam int FSET = FEATURE_COUNT * FB;
	// table entry: valid bit on top, then features, then address
	localparam int ENT = 1 + AB + FSET;
	// sum of four signed weights needs two bits more than one weight
	localparam int SW = (WB + 2 > SUM_BITS) ? WB + 2 : SUM_BITS;
	localparam int UW = SW + 4;
	localparam int CLR_A = ((1 << FB) > REJECT_ENTRIES) ? (1 << FB) : REJECT_ENTRIES;
	localparam int CLR_N = (CLR_A > ACCEPT_ENTRIES) ? CLR_A : ACCEPT_ENTRIES;
	localparam int CLRB = $clog2(CLR_N);
	localparam logic [WB-1:0] W_BIAS = WB'(1 << (WB - 1));
	localparam logic [WB-1:0] W_MAX  = '1;
	localparam logic signed [UW-1:0] W_TOP = UW'((1 << WB) - 1);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_TREAD, ST_TCHK, ST_RD, ST_SUM,
		ST_DECIDE, ST_UPD, ST_WR, ST_OUT
	} state_t;

	// registers
	state_t          state_q;
	logic signed [6:0] permit_q, raise_q, lower_q;
	logic [3:0]      step_q;
	logic [4:0]      pshift_q;
	logic [1:0]      act_q;
	logic [AB-1:0]   tgt_q;
	logic [FSET-1:0] feat_q;
	logic [CLRB-1:0] clr_q;
	logic [1:0]      cnt_q;       // feature being read or written
	logic            pass_q;      // demand: 0 reject table, 1 accept table
	logic signed [SW-1:0] sum_q;
	logic [ROW-1:0]  wrow_q [FEATURE_COUNT];
	logic [1:0]      dec_q, raises_q;
	logic            lowered_q, do_raise_q;

	// input fields
	logic [AB-1:0] in_tgt, in_trig;
	logic [CONF_BITS-1:0] in_conf;
	assign in_tgt  = s_axis_tdata[AB-1:0];
	assign in_trig = s_axis_tdata[2*AB-1:AB];
	assign in_conf = s_axis_tdata[2*AB+CONF_BITS-1:2*AB];

	// feature hash
	logic [AB-1:0] page;
	logic [FSET-1:0] in_feat;
	assign page = in_trig >> pshift_q;
	always_comb begin
		in_feat[0*FB +: FB] = FB'({{AB{1'b0}}, in_conf} ^ {{CONF_BITS{1'b0}}, page});
		in_feat[1*FB +: FB] = FB'(in_trig >> 6);
		in_feat[2*FB +: FB] = FB'(in_trig >> 12);
		in_feat[3*FB +: FB] = FB'(in_trig);
	end

	// tables, cleared by the reset sweep so the valid bits start low
	logic            rt_we, at_we, below_permit;
	logic [ENT-1:0]  rt_rd, at_rd, tbl_wdata;
	logic [RIB-1:0]  ri;
	logic [AIB-1:0]  ai;
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ri = clr_q[RIB-1:0];
			ai = clr_q[AIB-1:0];
		end else if (state_q == ST_IDLE) begin
			ri = in_tgt[RIB-1:0];
			ai = in_tgt[AIB-1:0];
		end else begin
			ri = tgt_q[RIB-1:0];
			ai = tgt_q[AIB-1:0];
		end
	end
	assign tbl_wdata = (state_q == ST_CLEAR) ? '0 : {1'b1, feat_q, tgt_q};
	assign below_permit = sum_q < SW'(permit_q);
	assign rt_we = (state_q == ST_CLEAR) ||
		((state_q == ST_DECIDE) && (act_q == ACT_CAND) && below_permit);
	assign at_we = (state_q == ST_CLEAR) ||
		((state_q == ST_DECIDE) && (act_q == ACT_CAND) && !below_permit);

	ppf_ram #(.WIDTH(ENT), .DEPTH(REJECT_ENTRIES)) u_rej (
		.clk(clk), .we(rt_we), .addr(ri), .wdata(tbl_wdata), .rdata(rt_rd));
	ppf_ram #(.WIDTH(ENT), .DEPTH(ACCEPT_ENTRIES)) u_acc (
		.clk(clk), .we(at_we), .addr(ai), .wdata(tbl_wdata), .rdata(at_rd));

	// weight memory: row f holds the weights of all four features at value f,
	// feature cnt_q sits in slot cnt_q of the row its own value selects
	logic [FB-1:0] w_addr;
	logic          w_we;
	logic [ROW-1:0] w_wdata, w_rd;
	ppf_ram #(.WIDTH(ROW), .DEPTH(1 << FB)) u_wgt (
		.clk(clk), .we(w_we), .addr(w_addr), .wdata(w_wdata), .rdata(w_rd));

	// weight just read, and as a signed value (counter minus bias flips the msb)
	logic [WB-1:0] rd_w;
	logic signed [WB-1:0] rd_sw;
	assign rd_w  = w_rd[cnt_q*WB +: WB];
	assign rd_sw = {~rd_w[WB-1], rd_w[WB-2:0]};

	// shared adder: sum accumulate while reading, saturating update while writing
	logic [WB-1:0] cur_w;
	logic signed [UW-1:0] add_a, add_b, add_res;
	logic [WB-1:0] sat_w;
	assign cur_w = wrow_q[cnt_q][cnt_q*WB +: WB];
	always_comb begin
		if (state_q == ST_WR) begin
			add_a = UW'(signed'({1'b0, cur_w}));
			add_b = UW'(signed'({1'b0, step_q}));
			add_res = do_raise_q ? add_a + add_b : add_a - add_b;
		end else begin
			add_a = UW'(sum_q);
			add_b = UW'(rd_sw);
			add_res = add_a + add_b;
		end
		if (add_res > W_TOP)  sat_w = W_MAX;
		else if (add_res < 0) sat_w = '0;
		else                  sat_w = add_res[WB-1:0];
	end

	always_comb begin
		w_we = 1'b0;
		w_addr = feat_q[cnt_q*FB +: FB];
		w_wdata = wrow_q[cnt_q];
		if (state_q == ST_CLEAR) begin
			w_we = 1'b1;
			w_addr = clr_q[FB-1:0];
			w_wdata = {FEATURE_COUNT{W_BIAS}};
		end else if (state_q == ST_WR) begin
			w_we = 1'b1;
			w_wdata[cnt_q*WB +: WB] = sat_w;
		end
	end

	logic hit;
	assign hit = (act_q == ACT_DEMAND && !pass_q) ?
		(rt_rd[ENT-1] && rt_rd[AB-1:0] == tgt_q) :
		(at_rd[ENT-1] && at_rd[AB-1:0] == tgt_q);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tuser = dec_q;
	assign m_axis_tdata = {6'd0, lowered_q, raises_q,
		((dec_q == DEC_NONE) ? {SUM_BITS{1'b0}} : sum_q[SUM_BITS-1:0])};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR; clr_q <= '0; cnt_q <= '0; pass_q <= 1'b0;
			permit_q <= 7'sd0; step_q <= 4'd1; raise_q <= 7'sd40;
			lower_q <= -7'sd40; pshift_q <= 5'd12;
			act_q <= ACT_DEMAND; tgt_q <= '0; feat_q <= '0; sum_q <= '0;
			for (int m = 0; m < FEATURE_COUNT; m++) wrow_q[m] <= '0;
			dec_q <= DEC_NONE; raises_q <= '0; lowered_q <= 1'b0; do_raise_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_PERMIT: permit_q <= cfg_data;
					REG_STEP:   step_q   <= cfg_data[3:0];
					REG_RAISE:  raise_q  <= cfg_data;
					REG_LOWER:  lower_q  <= cfg_data;
					REG_PSHIFT: pshift_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLRB'(CLR_N - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (s_axis_tvalid) begin
					act_q <= s_axis_tuser; tgt_q <= in_tgt; feat_q <= in_feat;
					dec_q <= DEC_NONE; raises_q <= '0; lowered_q <= 1'b0;
					pass_q <= 1'b0; cnt_q <= '0; sum_q <= '0;
					do_raise_q <= (s_axis_tuser == ACT_DEMAND);
					unique case (s_axis_tuser)
						ACT_CAND:   state_q <= ST_RD;
						ACT_DEMAND, ACT_EVICT: state_q <= ST_TREAD;
						default:    state_q <= ST_OUT;
					endcase
				end
				ST_TREAD: state_q <= ST_TCHK;   // table read data lands
				ST_TCHK: begin
					feat_q <= (act_q == ACT_DEMAND && !pass_q) ? rt_rd[AB +: FSET]
						: at_rd[AB +: FSET];
					cnt_q <= '0; sum_q <= '0;
					if (hit) state_q <= ST_RD;
					else if (act_q == ACT_DEMAND && !pass_q) begin
						pass_q <= 1'b1; state_q <= ST_TREAD;
					end else state_q <= ST_OUT;
				end
				ST_RD: state_q <= ST_SUM;
				ST_SUM: begin
					// keep the row for a later write and add this feature's weight
					wrow_q[cnt_q] <= w_rd;
					sum_q <= add_res[SW-1:0];
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 2'd3) state_q <= ST_DECIDE;
					else state_q <= ST_RD;
				end
				ST_DECIDE: begin
					cnt_q <= '0;
					if (act_q == ACT_CAND) begin
						dec_q <= below_permit ? DEC_REJECT : DEC_ACCEPT;
						state_q <= ST_OUT;
					end else if (act_q == ACT_DEMAND ? (sum_q <= SW'(raise_q))
						: (sum_q >= SW'(lower_q))) begin
						if (act_q == ACT_DEMAND) raises_q <= raises_q + 1'b1;
						else lowered_q <= 1'b1;
						state_q <= ST_WR;
					end else state_q <= ST_UPD;
				end
				ST_WR: begin
					// features sharing a row see the row as just written
					for (int m = 0; m < FEATURE_COUNT; m++)
						if (feat_q[m*FB +: FB] == w_addr) wrow_q[m] <= w_wdata;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 2'd3) state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (act_q == ACT_DEMAND && !pass_q) begin
						pass_q <= 1'b1; state_q <= ST_TREAD;
					end else state_q <= ST_OUT;
				end
				ST_OUT: if (m_axis_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
	a_dec_cand: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && act_q != ACT_CAND) |-> dec_q == DEC_NONE)
		else $error("decision on non-candidate");
	a_lower_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && lowered_q) |-> act_q == ACT_EVICT)
		else $error("lowered outside eviction");
	a_raise_demand: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && raises_q != 2'd0) |-> act_q == ACT_DEMAND)
		else $error("raise outside demand");
endmodule
